// ===== hdl/tllbp_pkg.sv =====
// Shared types and constants for the two-level local branch predictor.
// No dependencies.
package tllbp_pkg;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_ZERO       = 2'd0;
	localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
	localparam ctr_t CTR_MAX        = 2'd3;

endpackage

// ===== hdl/two_level_local_branch_predictor.sv =====
// A branch accepted in ST_IDLE has its history read into hist_rd_q, its pattern counter
// read in ST_READ_PAT and its result registered in ST_UPDATE once the output register is
// free; no new branch is accepted until the last is written back through the two tables.
// Reset (arst_n low, asynchronous) clears control state, then a clearing pass in ST_CLEAR
// steps clr_q over every address of both tables, writing each, before the first branch
// is accepted.
module two_level_local_branch_predictor
	import tllbp_pkg::*;
#(
	parameter int HISTORY_INDEX_BITS = 8,
	parameter int PATTERN_BITS       = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] branch_pc,
	input  logic        actual_taken,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        predicted_taken,
	output logic        mispredicted,
	output logic [31:0] mispredict_total
);

	localparam int HIST_DEPTH = 1 << HISTORY_INDEX_BITS;
	localparam int PAT_DEPTH  = 1 << PATTERN_BITS;
	localparam int CLR_BITS   = (HISTORY_INDEX_BITS > PATTERN_BITS) ?
	                            HISTORY_INDEX_BITS : PATTERN_BITS;

	typedef logic [HISTORY_INDEX_BITS-1:0] hidx_t;
	typedef logic [PATTERN_BITS-1:0]       hist_t;

	// The sequencer walks one branch through read history, read pattern counter and
	// write back. Only one branch is in flight, so the tables never see overlapping
	// accesses to one entry and need no forwarding.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_PAT,
		ST_UPDATE
	} state_t;

	state_t              state_q;
	logic [CLR_BITS-1:0] clr_q;
	logic [31:0]         miss_q;

	// Tables: per-branch histories and the shared pattern counters.
	hist_t hist_mem [HIST_DEPTH];
	ctr_t  ctr_mem  [PAT_DEPTH];

	hidx_t hidx_q;
	logic  taken_q;
	hist_t hist_rd_q;
	ctr_t  ctr_rd_q;

	logic  in_beat;
	logic  out_free;
	logic  upd_fire;
	logic  clearing;
	hidx_t in_hidx;
	logic  pred;
	logic  miss;
	hist_t hist_next;
	ctr_t  ctr_next;
	logic [31:0] miss_next;

	logic  hist_we;
	hidx_t hist_waddr;
	hist_t hist_wdata;
	logic  ctr_we;
	hist_t ctr_waddr;
	ctr_t  ctr_wdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign in_hidx  = branch_pc[HISTORY_INDEX_BITS+1:2];

	// The result register may be reloaded in the same cycle that its beat leaves.
	assign out_free = !out_valid || !out_stall;
	assign upd_fire = (state_q == ST_UPDATE) && out_free;
	assign clearing = (state_q == ST_CLEAR);

	// Prediction and the next values of the counter, the history and the miss count.
	always_comb begin
		pred = (ctr_rd_q >= CTR_WEAK_TAKEN);
		miss = (pred != taken_q);

		hist_next = hist_rd_q >> 1;
		hist_next[PATTERN_BITS-1] = taken_q;

		ctr_next = ctr_rd_q;
		if (taken_q) begin
			if (ctr_rd_q != CTR_MAX) ctr_next = ctr_rd_q + 2'd1;
		end else begin
			if (ctr_rd_q != CTR_ZERO) ctr_next = ctr_rd_q - 2'd1;
		end

		miss_next = miss_q;
		if (miss && (miss_q != 32'hFFFF_FFFF)) miss_next = miss_q + 32'd1;
	end

	// Write ports are shared between the clearing pass and the write-back.
	always_comb begin
		hist_we    = clearing || upd_fire;
		hist_waddr = clearing ? clr_q[HISTORY_INDEX_BITS-1:0] : hidx_q;
		hist_wdata = clearing ? '0 : hist_next;
		ctr_we     = clearing || upd_fire;
		ctr_waddr  = clearing ? clr_q[PATTERN_BITS-1:0] : hist_rd_q;
		ctr_wdata  = clearing ? CTR_WEAK_TAKEN : ctr_next;
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		if (in_beat) hist_rd_q <= hist_mem[in_hidx];
	end

	always_ff @(posedge clk) begin
		if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
		if (state_q == ST_READ_PAT) ctr_rd_q <= ctr_mem[hist_rd_q];
	end

	// Captured branch fields, held while the branch is in flight.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			hidx_q  <= in_hidx;
			taken_q <= actual_taken;
		end
	end

	// Sequencer, miss counter and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_q            <= '0;
			miss_q           <= '0;
			out_valid        <= 1'b0;
			predicted_taken  <= 1'b0;
			mispredicted     <= 1'b0;
			mispredict_total <= '0;
		end else begin
			// A new result takes the register; otherwise a departing beat empties it.
			if (upd_fire) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_READ_PAT;
				end
				ST_READ_PAT: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (out_free) begin
						miss_q           <= miss_next;
						predicted_taken  <= pred;
						mispredicted     <= miss;
						mispredict_total <= miss_next;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/tllbp_checker.sv =====
// Port-level checks for the two-level local branch predictor, bound to its top level.
// Depends only on the top level's port names.
module tllbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        predicted_taken,
	input logic        mispredicted,
	input logic [31:0] mispredict_total
);

	logic        out_beat;
	logic [31:0] last_total_q;

	assign out_beat = out_valid && !out_stall;

	// Miss total of the most recent result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (out_beat) begin
			last_total_q <= mispredict_total;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(predicted_taken)
			&& $stable(mispredicted) && $stable(mispredict_total))
		else $error("result beat changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second branch accepted while one is in flight");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && mispredicted && (last_total_q != 32'hFFFF_FFFF)
			|-> mispredict_total == last_total_q + 32'd1)
		else $error("miss total did not advance on a misprediction");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (!mispredicted || (last_total_q == 32'hFFFF_FFFF))
			|-> mispredict_total == last_total_q)
		else $error("miss total moved without a countable misprediction");

endmodule

bind two_level_local_branch_predictor tllbp_checker u_tllbp_checker (.*);
